/* rtl/gfrm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfrm_pkg
// Shared types and constants of the greedy face-rectangle merge block.
// ----------------------------------------------------------------------------
package gfrm_pkg;

  // Default sizing of the grid store
  localparam int MAX_EXTENT_DEF = 16;
  localparam int TYPE_BITS_DEF  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_DATA_W-1:0] EXTENT_RESET = 5'd16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_MODE = 2'd0,
    CFG_EXTENT_X   = 2'd1,
    CFG_EXTENT_Y   = 2'd2,
    CFG_EXTENT_Z   = 2'd3
  } cfg_reg_e;

  // Item operations
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Plane modes (code 3 behaves as PLANE_XY)
  localparam logic [1:0] PLANE_ZX = 2'd0;
  localparam logic [1:0] PLANE_ZY = 2'd1;

  typedef struct packed {
    logic       operation;
    logic [7:0] cell_type;
  } in_item_t;

  typedef struct packed {
    logic       done_res;
    logic [7:0] rect_type;
    logic [3:0] origin_x;
    logic [3:0] origin_y;
    logic [3:0] origin_z;
    logic [4:0] span_x;
    logic [4:0] span_y;
    logic [4:0] span_z;
  } out_item_t;

endpackage

/* rtl/gfrm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gfrm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfrm_div
// Restoring divider, one quotient bit per cycle; splits a raster position
// into coordinates.
// ----------------------------------------------------------------------------
module gfrm_div #(
  parameter int DVD_W = 13,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  // shift next dividend bit into the partial remainder
  assign trial = {remainder, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        cnt       <= CNT_W'(DVD_W);
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
      end else if (running) begin
        if (fits) begin
          remainder <= DVS_W'(trial - {1'b0, dvs});
        end else begin
          remainder <= DVS_W'(trial);
        end
        quotient <= {quotient[DVD_W-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/greedy_face_rectangle_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_face_rectangle_merge
// Loads a 3-D grid of face types and hands out greedily merged rectangles.
// ----------------------------------------------------------------------------
// One item is taken while start is high and busy is low; busy stays high until
// the item is finished, and a fetch result is shown for one cycle on
// result_valid, which the receiver cannot stall. The load that begins a grid
// first clears the visited map, one entry a cycle; the map holds MAX_EXTENT
// rounded up to a power of two, cubed, entries (4096 by default). A fetch
// scans cells, grows the width and then adds rows, each probe going through
// the single read port of the cell and visited memories. After any register
// write, the first item of each kind also passes through the shared divider
// to turn its raster position back into coordinates.
// ----------------------------------------------------------------------------
module greedy_face_rectangle_merge #(
  parameter int MAX_EXTENT = gfrm_pkg::MAX_EXTENT_DEF,
  parameter int TYPE_BITS  = gfrm_pkg::TYPE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  gfrm_pkg::in_item_t             item,
  output logic                           result_valid,
  output gfrm_pkg::out_item_t            result,
  input  logic                           cfg_write,
  input  logic [gfrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfrm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gfrm_pkg::*;

  localparam int CW    = $clog2(MAX_EXTENT);
  localparam int EXT_W = $clog2(MAX_EXTENT + 1);
  localparam int EW1   = EXT_W + 1;
  localparam int POS_W = $clog2(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT + 1);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } coord_t;

  typedef enum logic [4:0] {
    S_IDLE, S_TOT1, S_TOT2, S_LOAD, S_CLEAR, S_STORE, S_FETCH, S_SCAN_CHK,
    S_DEC1, S_DEC1W, S_DEC2, S_DEC2W, S_WID, S_WID_CHK, S_HGT, S_ROW,
    S_ROW_CHK, S_MARK
  } state_t;

  state_t state;

  // configuration registers
  logic [1:0]            plane_mode;
  logic [CFG_DATA_W-1:0] extent_x, extent_y, extent_z;
  logic [EXT_W-1:0]      cx, cy, cz;

  // item and sequencer registers
  logic                  op_r;
  logic [7:0]            type_in;
  logic [2*EXT_W-1:0]    exy;
  logic [POS_W-1:0]      total;
  logic [POS_W-1:0]      load_pos, scan_pos, q1;
  coord_t                load_c, scan_c, org;
  logic                  load_sync, scan_sync, dec_scan;
  logic [AW-1:0]         clr_addr;
  logic [TYPE_BITS-1:0]  t_r;
  logic [EXT_W-1:0]      w, h, i;

  // memory ports
  logic [TYPE_BITS-1:0]  cell_rd;
  logic                  vis_rd, vis_we, vis_wd;
  logic [AW-1:0]         rd_addr, vis_waddr;

  // divider ports
  logic                  div_start, div_done;
  logic [POS_W-1:0]      div_dvd, div_quo;
  logic [EXT_W-1:0]      div_dvs, div_rem;

  // plane decode and probe
  logic                  m0, m1, m2;
  logic [EXT_W-1:0]      pu, pv, ew, eh;
  logic [CW-1:0]         ow, ov;
  logic [EW1-1:0]        sx, sy, sz;
  coord_t                probe;
  logic                  found, match, w_room, h_room;
  out_item_t             rect_res, done_item;

  function automatic logic [EXT_W-1:0] clamp_ext(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return EXT_W'(1);
    end else if (int'(v) > MAX_EXTENT) begin
      return EXT_W'(MAX_EXTENT);
    end
    return EXT_W'(v);
  endfunction

  // raster step: z inner, then y, then x
  function automatic coord_t raster_next(input coord_t c, input logic [EXT_W-1:0] ex,
                                         input logic [EXT_W-1:0] ey,
                                         input logic [EXT_W-1:0] ez);
    coord_t n;
    n = c;
    if (EW1'(c.z) + EW1'(1) < EW1'(ez)) begin
      n.z = c.z + CW'(1);
    end else begin
      n.z = '0;
      if (EW1'(c.y) + EW1'(1) < EW1'(ey)) begin
        n.y = c.y + CW'(1);
      end else begin
        n.y = '0;
        if (EW1'(c.x) + EW1'(1) < EW1'(ex)) begin
          n.x = c.x + CW'(1);
        end else begin
          n.x = '0;
        end
      end
    end
    return n;
  endfunction

  assign cx = clamp_ext(extent_x);
  assign cy = clamp_ext(extent_y);
  assign cz = clamp_ext(extent_z);

  // axis choice: width axis z or x, height axis x or y
  assign m0 = plane_mode == PLANE_ZX;
  assign m1 = plane_mode == PLANE_ZY;
  assign m2 = plane_mode[1];
  assign ow = m2 ? org.x : org.z;
  assign ew = m2 ? cx : cz;
  assign ov = m0 ? org.x : org.y;
  assign eh = m0 ? cx : cy;

  // probe offsets along width and height
  assign pu = (state == S_WID || state == S_WID_CHK) ? w : i;
  assign pv = (state == S_WID || state == S_WID_CHK) ? '0 : h;
  assign sx = EW1'(org.x) + (m2 ? EW1'(pu) : '0) + (m0 ? EW1'(pv) : '0);
  assign sy = EW1'(org.y) + ((m1 || m2) ? EW1'(pv) : '0);
  assign sz = EW1'(org.z) + ((m0 || m1) ? EW1'(pu) : '0);
  assign probe = '{x: CW'(sx), y: CW'(sy), z: CW'(sz)};

  assign w_room = EW1'(ow) + EW1'(w) < EW1'(ew);
  assign h_room = EW1'(ov) + EW1'(h) < EW1'(eh);
  assign found  = cell_rd != '0 && !vis_rd;
  assign match  = cell_rd == t_r && !vis_rd;

  // memory addressing
  assign rd_addr   = (state == S_FETCH) ? scan_c : probe;
  assign vis_we    = state == S_CLEAR || state == S_MARK ||
                     (state == S_SCAN_CHK && found) || (state == S_WID_CHK && match);
  assign vis_wd    = state != S_CLEAR;
  assign vis_waddr = (state == S_CLEAR) ? clr_addr :
                     (state == S_SCAN_CHK) ? scan_c : probe;

  gfrm_ram #(.WIDTH(TYPE_BITS), .DEPTH(DEPTH)) u_cells (
    .clk(clk), .we(state == S_STORE), .waddr(load_c), .wdata(TYPE_BITS'(type_in)),
    .raddr(rd_addr), .rdata(cell_rd)
  );

  gfrm_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wd),
    .raddr(rd_addr), .rdata(vis_rd)
  );

  // position to coordinates: pos / ez, then quotient / ey
  assign div_start = state == S_DEC1 || state == S_DEC2;
  assign div_dvd   = (state == S_DEC2) ? q1 : (dec_scan ? scan_pos : load_pos);
  assign div_dvs   = (state == S_DEC2) ? cy : cz;

  gfrm_div #(.DVD_W(POS_W), .DVS_W(EXT_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_quo), .remainder(div_rem)
  );

  // finished rectangle
  always_comb begin
    rect_res           = '0;
    rect_res.rect_type = 8'(t_r);
    rect_res.origin_x  = 4'(org.x);
    rect_res.origin_y  = 4'(org.y);
    rect_res.origin_z  = 4'(org.z);
    rect_res.span_x    = m2 ? 5'(w) : (m0 ? 5'(h) : 5'd1);
    rect_res.span_y    = (m1 || m2) ? 5'(h) : 5'd1;
    rect_res.span_z    = (m0 || m1) ? 5'(w) : 5'd1;
    done_item          = '0;
    done_item.done_res = 1'b1;
  end

  assign busy = state != S_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      plane_mode   <= PLANE_ZX;
      extent_x     <= EXTENT_RESET;
      extent_y     <= EXTENT_RESET;
      extent_z     <= EXTENT_RESET;
      load_pos     <= '0;
      scan_pos     <= '0;
      load_c       <= '0;
      scan_c       <= '0;
      load_sync    <= 1'b1;
      scan_sync    <= 1'b1;
      dec_scan     <= 1'b0;
      clr_addr     <= '0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_PLANE_MODE: plane_mode <= cfg_data[1:0];
          CFG_EXTENT_X:   extent_x   <= cfg_data;
          CFG_EXTENT_Y:   extent_y   <= cfg_data;
          CFG_EXTENT_Z:   extent_z   <= cfg_data;
          default:        plane_mode <= plane_mode;
        endcase
        load_sync <= 1'b0;
        scan_sync <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= item.operation;
            type_in <= item.cell_type;
            state   <= S_TOT1;
          end
        end
        S_TOT1: begin
          exy   <= cx * cy;
          state <= S_TOT2;
        end
        S_TOT2: begin
          total <= POS_W'(exy) * POS_W'(cz);
          state <= (op_r == OP_LOAD) ? S_LOAD : S_FETCH;
        end
        S_LOAD: begin
          if (load_pos >= total || load_pos == '0) begin
            load_pos  <= '0;
            load_c    <= '0;
            load_sync <= 1'b1;
            scan_pos  <= '0;
            scan_c    <= '0;
            scan_sync <= 1'b1;
            clr_addr  <= '0;
            state     <= S_CLEAR;
          end else if (!load_sync) begin
            dec_scan <= 1'b0;
            state    <= S_DEC1;
          end else begin
            state <= S_STORE;
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (load_pos + POS_W'(1) >= total) begin
            load_pos <= '0;
            load_c   <= '0;
          end else begin
            load_pos <= load_pos + POS_W'(1);
            load_c   <= raster_next(load_c, cx, cy, cz);
          end
          state <= S_IDLE;
        end
        S_DEC1: state <= S_DEC1W;
        S_DEC1W: begin
          if (div_done) begin
            q1 <= div_quo;
            if (dec_scan) scan_c.z <= CW'(div_rem);
            else          load_c.z <= CW'(div_rem);
            state <= S_DEC2;
          end
        end
        S_DEC2: state <= S_DEC2W;
        S_DEC2W: begin
          if (div_done) begin
            if (dec_scan) begin
              scan_c.y  <= CW'(div_rem);
              scan_c.x  <= CW'(div_quo);
              scan_sync <= 1'b1;
              state     <= S_FETCH;
            end else begin
              load_c.y  <= CW'(div_rem);
              load_c.x  <= CW'(div_quo);
              load_sync <= 1'b1;
              state     <= S_STORE;
            end
          end
        end
        S_FETCH: begin
          if (scan_pos >= total) begin
            result       <= done_item;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (!scan_sync) begin
            dec_scan <= 1'b1;
            state    <= S_DEC1;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          scan_pos <= scan_pos + POS_W'(1);
          scan_c   <= raster_next(scan_c, cx, cy, cz);
          if (found) begin
            t_r   <= cell_rd;
            org   <= scan_c;
            w     <= EXT_W'(1);
            state <= S_WID;
          end else begin
            state <= S_FETCH;
          end
        end
        // grow along the width axis
        S_WID: begin
          if (w_room) begin
            state <= S_WID_CHK;
          end else begin
            h     <= EXT_W'(1);
            state <= S_HGT;
          end
        end
        S_WID_CHK: begin
          if (match) begin
            w     <= w + EXT_W'(1);
            state <= S_WID;
          end else begin
            h     <= EXT_W'(1);
            state <= S_HGT;
          end
        end
        // grow whole rows along the height axis
        S_HGT: begin
          if (h_room) begin
            i     <= '0;
            state <= S_ROW;
          end else begin
            result       <= rect_res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_ROW: state <= S_ROW_CHK;
        S_ROW_CHK: begin
          if (!match) begin
            result       <= rect_res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end else if (i + EXT_W'(1) == w) begin
            i     <= '0;
            state <= S_MARK;
          end else begin
            i     <= i + EXT_W'(1);
            state <= S_ROW;
          end
        end
        S_MARK: begin
          if (i + EXT_W'(1) == w) begin
            h     <= h + EXT_W'(1);
            state <= S_HGT;
          end else begin
            i <= i + EXT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_store_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_STORE |-> load_pos < total)
    else $error("load position outside grid at store");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.done_res) |-> (result.rect_type == '0 &&
      result.span_x == '0 && result.span_y == '0 && result.span_z == '0))
    else $error("done result carries rectangle fields");

endmodule
